>>> rtl/mewin_pkg.sv
// Shared types and constants for the sliding-window event counter.
package mewin_pkg;

  localparam int unsigned RING_DEPTH_DEF = 1024;
  localparam int unsigned TIME_W         = 32;
  localparam int unsigned CNT_W          = 11;
  localparam logic [TIME_W-1:0] WL_RESET = 32'd60;

  // Output beat layout in tdata, lowest bit first.
  localparam int unsigned OUT_DATA_W = 152;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_CMP,
    SEQ_FETCH
  } seq_state_t;

  typedef struct packed {
    logic in_ready;
    logic pop;
    logic ovf_pop;
    logic push;
  } seq_ctrl_t;

endpackage

>>> rtl/mewin_ring.sv
// Timestamp ring storage: one write port, one registered read port.
module mewin_ring import mewin_pkg::*; #(
  parameter int unsigned DEPTH = RING_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [TIME_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [TIME_W-1:0] rdata
);

  logic [TIME_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/mewin_cmp.sv
// Age compare: decides whether the oldest entry has left the window.
module mewin_cmp import mewin_pkg::*; (
  input  logic              nonempty,
  input  logic [TIME_W-1:0] new_time,
  input  logic [TIME_W-1:0] old_time,
  input  logic [TIME_W-1:0] win_len,
  output logic              pop_ok
);

  logic [TIME_W:0] diff;

  // The borrow bit catches a timestamp that went backwards; such an entry stays.
  assign diff   = {1'b0, new_time} - {1'b0, old_time};
  assign pop_ok = nonempty && !diff[TIME_W] && (diff[TIME_W-1:0] >= win_len);

endmodule

>>> rtl/mewin_seq.sv
// Sequencer: walks the pops of one item, then the push and result.
module mewin_seq import mewin_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  logic      pop_ok,
  input  logic      full,
  input  logic      out_free,
  output seq_ctrl_t ctrl
);

  seq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SEQ_IDLE: begin
        if (in_fire) state_nxt = SEQ_CMP;
      end
      SEQ_CMP: begin
        if (pop_ok) begin
          state_nxt = SEQ_CMP;
        end else if (full) begin
          state_nxt = SEQ_FETCH;
        end else if (out_free) begin
          state_nxt = SEQ_IDLE;
        end
      end
      SEQ_FETCH: begin
        if (out_free) state_nxt = SEQ_IDLE;
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state_r)
      SEQ_IDLE: begin
        ctrl.in_ready = 1'b1;
      end
      SEQ_CMP: begin
        ctrl.pop     = pop_ok;
        ctrl.ovf_pop = !pop_ok && full;
        ctrl.push    = !pop_ok && !full && out_free;
      end
      SEQ_FETCH: begin
        ctrl.push = out_free;
      end
      default: ctrl = '0;
    endcase
  end

endmodule

>>> rtl/max_events_in_time_window.sv
// Sliding-window event counter: finds the densest window of event timestamps.
//
// Input beats carry one timestamp each in in_tdata; in_tlast marks the last
// event of a sequence. Each accepted beat yields exactly one output beat with
// the running best window (count, first/last index and time), the count of
// the window ending at this event and a sticky ring-overflow flag in out_tuser.
// out_tlast repeats in_tlast; after that beat all sequence state is cleared.
// The window length must be written on the cfg channel while the block is idle;
// the block itself does not enforce it. It resets to 60.
//
// After the accepting edge the sequencer pops each stored timestamp that
// leaves the window, one per cycle since the ring RAM does one read per cycle,
// then loads the result into the output register. A full ring first drops its
// oldest entry, and the push follows from the fetch state. in_tready is high
// only in idle, which follows each load, so a new item is taken only once the
// last one is loaded. If the receiver stalls, the next item is still taken and
// processed up to its push, which then waits for the output register to drain.
// Reset clears the control and best-window state; the ring needs no clearing pass.
module max_events_in_time_window import mewin_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TIME_W-1:0]     in_tdata,   // event_time
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // best_count[10:0], best_first_index[42:11], best_last_index[74:43],
  // best_first_time[106:75], best_last_time[138:107], window_count[149:139]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,  // overflow
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [TIME_W-1:0]     cfg_data
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned FW = $clog2(RING_DEPTH + 1);
  localparam logic [FW-1:0] FULL_CNT  = FW'(RING_DEPTH);
  localparam logic [AW-1:0] HEAD_LAST = AW'(RING_DEPTH - 1);
  localparam logic [FW:0]   DEPTH_X   = (FW + 1)'(RING_DEPTH);

  seq_ctrl_t ctrl;
  logic in_fire, pop_ok, full, out_free, any_pop;

  logic [TIME_W-1:0] wl_r, t_r, rdata;
  logic              last_r;
  logic [AW-1:0]     head_r, head_nxt, head_inc, waddr;
  logic [FW-1:0]     fill_r, fill_nxt, fill_inc;
  logic [FW:0]       wsum;
  logic [TIME_W-1:0] idx_r;
  logic [FW-1:0]     bcnt_r;
  logic [TIME_W-1:0] bfi_r, bli_r, bft_r, blt_r;
  logic              ovf_r;

  logic [FW-1:0]     bcnt_v;
  logic [TIME_W-1:0] bfi_v, bli_v, bft_v, blt_v, first_time;
  logic              ovf_v;
  logic [FW+CNT_W-1:0] bcnt_ext, wcnt_ext;

  logic                  out_valid_r, out_last_r, out_ovf_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  assign in_fire   = in_tvalid && ctrl.in_ready;
  assign in_tready = ctrl.in_ready;
  assign cfg_ready = 1'b1;
  assign full      = (fill_r == FULL_CNT);
  assign out_free  = !out_valid_r || out_tready;
  assign any_pop   = ctrl.pop || ctrl.ovf_pop;

  mewin_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .pop_ok   (pop_ok),
    .full     (full),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  mewin_cmp u_cmp (
    .nonempty (fill_r != '0),
    .new_time (t_r),
    .old_time (rdata),
    .win_len  (wl_r),
    .pop_ok   (pop_ok)
  );

  // Ring pointer arithmetic, modulo the depth.
  assign head_inc = (head_r == HEAD_LAST) ? '0 : head_r + AW'(1);
  assign wsum     = {1'b0, {(FW-AW){1'b0}}, head_r} + {1'b0, fill_r};
  assign waddr    = (wsum >= DEPTH_X) ? AW'(wsum - DEPTH_X) : AW'(wsum);
  assign fill_inc = fill_r + FW'(1);

  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (any_pop) begin
      head_nxt = head_inc;
      fill_nxt = fill_r - FW'(1);
    end else if (ctrl.push) begin
      if (last_r) begin
        head_nxt = '0;
        fill_nxt = '0;
      end else begin
        fill_nxt = fill_inc;
      end
    end
  end

  // The read address follows the head, so the oldest entry is always on rdata.
  mewin_ring #(.DEPTH(RING_DEPTH), .AW(AW)) u_ring (
    .clk   (clk),
    .we    (ctrl.push),
    .waddr (waddr),
    .wdata (t_r),
    .raddr (head_nxt),
    .rdata (rdata)
  );

  // Running best after this item's push.
  assign first_time = (fill_r == '0) ? t_r : rdata;

  always_comb begin
    bcnt_v = bcnt_r;
    bfi_v  = bfi_r;
    bli_v  = bli_r;
    bft_v  = bft_r;
    blt_v  = blt_r;
    if (fill_inc > bcnt_r) begin
      bcnt_v = fill_inc;
      bfi_v  = idx_r - TIME_W'(fill_inc) + TIME_W'(1);
      bli_v  = idx_r;
      bft_v  = first_time;
      blt_v  = t_r;
    end
  end

  assign ovf_v    = ovf_r;
  assign bcnt_ext = {{CNT_W{1'b0}}, bcnt_v};
  assign wcnt_ext = {{CNT_W{1'b0}}, fill_inc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r   <= WL_RESET;
      head_r <= '0;
      fill_r <= '0;
      idx_r  <= '0;
      bcnt_r <= '0;
      bfi_r  <= '0;
      bli_r  <= '0;
      bft_r  <= '0;
      blt_r  <= '0;
      ovf_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        wl_r <= cfg_data;
      end
      head_r <= head_nxt;
      fill_r <= fill_nxt;
      if (ctrl.ovf_pop) begin
        ovf_r <= 1'b1;
      end
      if (ctrl.push) begin
        if (last_r) begin
          idx_r  <= '0;
          bcnt_r <= '0;
          bfi_r  <= '0;
          bli_r  <= '0;
          bft_r  <= '0;
          blt_r  <= '0;
          ovf_r  <= 1'b0;
        end else begin
          idx_r  <= idx_r + TIME_W'(1);
          bcnt_r <= bcnt_v;
          bfi_r  <= bfi_v;
          bli_r  <= bli_v;
          bft_r  <= bft_v;
          blt_r  <= blt_v;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      t_r    <= in_tdata;
      last_r <= in_tlast;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      out_data_r <= {2'b00, wcnt_ext[CNT_W-1:0], blt_v, bft_v, bli_v, bfi_v,
                     bcnt_ext[CNT_W-1:0]};
      out_ovf_r  <= ovf_v;
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ovf_r;
  assign out_tlast  = out_last_r;

endmodule
